>>> hw/rtl/pox_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pox_pkg
// Shared types and constants of the pulse oximetry ratio block.
// ----------------------------------------------------------------------------
package pox_pkg;

  localparam int WINDOW_DEF      = 100;
  localparam int HOP_DEF         = 25;
  localparam int SAMPLE_BITS_DEF = 18;

  localparam int FIELD_BITS = 18;
  localparam int WIDE_BITS  = 24;

  localparam logic [19:0] R_MAX       = 20'hFFFFF;
  localparam logic [14:0] SPO2_HI     = 15'd25574;
  localparam logic [14:0] SPO2_LO     = 15'd17920;
  localparam logic [33:0] NUM_BASE    = 34'd716439552;
  localparam logic [33:0] NUM_LO      = 34'd458752000;
  localparam logic [63:0] SCALE_DIV   = 64'd25600;
  localparam logic [11:0] SLOPE       = 12'd2330;

  localparam logic [17:0] THRESH_RST  = 18'd50000;
  localparam logic [8:0]  KEEP_RST    = 9'd179;
  localparam logic [8:0]  KEEP_MAX    = 9'd256;

  localparam int MUL_STEPS  = 32;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;

  typedef enum logic {
    REG_THRESH = 1'b0,
    REG_KEEP   = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALK_END,
    ST_MULQ,
    ST_MULS,
    ST_SQRT,
    ST_DIVA,
    ST_DIVR,
    ST_NUM,
    ST_DIVS,
    ST_SMOOTH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [17:0] red_sample;
    logic [17:0] ir_sample;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [14:0] spo2_smoothed;
    logic [14:0] spo2_instant;
    logic [19:0] ratio_r;
  } out_word_t;

endpackage
`default_nettype wire

>>> hw/rtl/pox_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pox_mul
// Shift-and-add multiplier, one multiplier bit per cycle, 64-bit product.
// ----------------------------------------------------------------------------
module pox_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod,
  output logic             done
);
  import pox_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [63:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[62:0], 1'b0};
        b_r   <= {1'b0, b_r[31:1]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

>>> hw/rtl/pox_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pox_sqrt
// Integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
module pox_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] v,
  output logic      [31:0] root,
  output logic             done
);
  import pox_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= {1'b0, res_r[63:1]} + bit_r;
        end else begin
          res_r <= {1'b0, res_r[63:1]};
        end
        bit_r <= {2'b00, bit_r[63:2]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        rem_r  <= v;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule
`default_nettype wire

>>> hw/rtl/pox_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pox_div
// Restoring divider, 64-bit dividend and divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pox_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] n,
  input  wire logic [63:0] d,
  output logic      [63:0] quo,
  output logic             done
);
  import pox_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r;
  logic [63:0] den_r;
  logic [63:0] rem_r;
  logic [64:0] sh;
  logic        qbit;

  assign sh   = {rem_r, num_r[63]};
  assign qbit = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (qbit) begin
          rem_r <= 64'(sh - {1'b0, den_r});
        end else begin
          rem_r <= sh[63:0];
        end
        num_r <= {num_r[62:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        num_r  <= n;
        den_r  <= d;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule
`default_nettype wire

>>> hw/rtl/pulse_oximetry_rms_ratio.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_oximetry_rms_ratio
// Sliding-window ratio-of-ratios SpO2 estimator with exponential smoothing.
//
//   Channel  Dir  Handshake          Word
//   in       in   in_valid/in_stall  in_data  (red_sample, ir_sample)
//   out      out  out_valid/out_stall out_data (status, smoothed, instant, R)
//   cfg      in   APB psel/penable   IR threshold at 0, keep weight at 4
//
// A word that gives no result is taken without a stall. A hop word holds in_stall
// high through a window walk, then per color two serial multiplies, a square
// root and a divide, then two more divides, and then the finish and emit steps.
// Reset is synchronous; the window needs no clearing pass. in_stall is high
// while a word is in work; a finished word waits in the output register.
// ----------------------------------------------------------------------------
module pulse_oximetry_rms_ratio #(
  parameter int WINDOW      = pox_pkg::WINDOW_DEF,
  parameter int HOP         = pox_pkg::HOP_DEF,
  parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pox_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pox_pkg::out_word_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import pox_pkg::*;

  localparam int AW  = $clog2(WINDOW);
  localparam int FCW = $clog2(WINDOW + 1);
  localparam int HCW = $clog2(HOP + 1);

  state_t state_r, state_nxt;

  logic [17:0]            thr_r;
  logic [8:0]             keep_r;
  logic [FCW-1:0]         fill_r;
  logic [HCW-1:0]         hop_r;
  logic [AW-1:0]          wp_r;
  logic [14:0]            sm_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;
  out_word_t              res_r;

  logic [SAMPLE_BITS-1:0] red_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] ir_mem  [WINDOW];
  logic [SAMPLE_BITS-1:0] red_q_r;
  logic [SAMPLE_BITS-1:0] ir_q_r;
  logic [AW-1:0]          rd_addr_r;
  logic                   rd_v_r;

  logic [31:0]            sr_r, si_r;
  logic [63:0]            qr_r, qi_r;
  logic                   col_r;
  logic                   launch_r;
  logic [63:0]            t_r;
  logic [63:0]            v_r;
  logic [31:0]            root_r;
  logic [32:0]            ar_r, ai_r;
  logic [19:0]            rr_r;
  logic signed [33:0]     num_r;
  logic [14:0]            inst_r;

  logic [WIDE_BITS-1:0]   red_w, ir_w;
  logic [SAMPLE_BITS-1:0] red_m, ir_m;
  logic                   in_acc, fill_full, finger, hop_fire, out_free;
  logic [31:0]            s_sel;
  logic [63:0]            q_sel;
  logic [2*SAMPLE_BITS-1:0] rsq, isq;

  logic        mul_start, mul_done, sq_start, sq_done, div_start, div_done;
  logic [63:0] mul_a, mul_prod, div_n, div_d, div_q;
  logic [31:0] mul_b, sq_root;
  logic        unit_go;
  logic        s_zero, r_zero, num_low;
  logic [31:0] slope_r;
  logic [8:0]  keep9;
  logic [24:0] sm_sum;
  logic [14:0] sm_new;
  logic        cfg_wr;

  assign red_w     = WIDE_BITS'(in_data.red_sample);
  assign ir_w      = WIDE_BITS'(in_data.ir_sample);
  assign red_m     = red_w[SAMPLE_BITS-1:0];
  assign ir_m      = ir_w[SAMPLE_BITS-1:0];
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign fill_full = (fill_r == FCW'(WINDOW));
  assign finger    = fill_full && (WIDE_BITS'(ir_m) < WIDE_BITS'(thr_r));
  assign hop_fire  = fill_full && ((32'(hop_r) + 32'd1) >= 32'(HOP));
  assign out_free  = !out_valid_r || !out_stall;
  assign s_sel     = col_r ? si_r : sr_r;
  assign q_sel     = col_r ? qi_r : qr_r;
  assign rsq       = red_q_r * red_q_r;
  assign isq       = ir_q_r * ir_q_r;
  assign s_zero    = (s_sel == 32'd0);
  assign r_zero    = (sr_r == 32'd0) || (ai_r == 33'd0);
  assign num_low   = (num_r < $signed(NUM_LO));
  assign slope_r   = 32'(SLOPE * rr_r);
  assign keep9     = (keep_r > KEEP_MAX) ? KEEP_MAX : keep_r;
  assign sm_sum    = 25'(keep9 * sm_r) + 25'((KEEP_MAX - keep9) * inst_r) + 25'd128;
  assign sm_new    = (sm_r == 15'd0) ? inst_r : sm_sum[22:8];
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (finger) begin
            state_nxt = ST_EMIT;
          end else if (hop_fire) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rd_addr_r == AW'(WINDOW - 1)) begin
          state_nxt = ST_WALK_END;
        end
      end
      ST_WALK_END: state_nxt = ST_MULQ;
      ST_MULQ:     if (mul_done) state_nxt = ST_MULS;
      ST_MULS:     if (mul_done) state_nxt = ST_SQRT;
      ST_SQRT:     if (sq_done) state_nxt = ST_DIVA;
      ST_DIVA: begin
        if (s_zero || div_done) begin
          state_nxt = col_r ? ST_DIVR : ST_MULQ;
        end
      end
      ST_DIVR:     if (r_zero || div_done) state_nxt = ST_NUM;
      ST_NUM:      state_nxt = ST_DIVS;
      ST_DIVS:     if (num_low || div_done) state_nxt = ST_SMOOTH;
      ST_SMOOTH:   state_nxt = ST_EMIT;
      ST_EMIT:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    mul_a     = q_sel;
    mul_b     = 32'(WINDOW);
    div_n     = {4'b0, root_r, 28'b0};
    div_d     = 64'(s_sel);
    unit_go   = !launch_r;
    case (state_r)
      ST_MULQ: mul_start = unit_go;
      ST_MULS: begin
        mul_start = unit_go;
        mul_a     = 64'(s_sel);
        mul_b     = s_sel;
      end
      ST_SQRT: sq_start = unit_go;
      ST_DIVA: div_start = unit_go && !s_zero;
      ST_DIVR: begin
        div_start = unit_go && !r_zero;
        div_n     = {15'b0, ar_r, 16'b0};
        div_d     = 64'(ai_r);
      end
      ST_DIVS: begin
        div_start = unit_go && !num_low;
        div_n     = 64'(num_r[29:0]);
        div_d     = SCALE_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && !finger) begin
      red_mem[wp_r] <= red_m;
      ir_mem[wp_r]  <= ir_m;
    end
    red_q_r <= red_mem[rd_addr_r];
    ir_q_r  <= ir_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESH_RST;
      keep_r      <= KEEP_RST;
      fill_r      <= '0;
      hop_r       <= '0;
      wp_r        <= '0;
      sm_r        <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      col_r       <= 1'b0;
      launch_r    <= 1'b0;
      rd_addr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_THRESH) begin
          thr_r <= pwdata[17:0];
        end else begin
          keep_r <= pwdata[8:0];
        end
      end
      if (mul_start || sq_start || div_start) begin
        launch_r <= 1'b1;
      end else if (mul_done || sq_done || div_done) begin
        launch_r <= 1'b0;
      end
      rd_v_r <= (state_r == ST_WALK);
      if (rd_v_r) begin
        sr_r <= sr_r + 32'(red_q_r);
        si_r <= si_r + 32'(ir_q_r);
        qr_r <= qr_r + 64'(rsq);
        qi_r <= qi_r + 64'(isq);
      end
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rd_addr_r <= '0;
          col_r     <= 1'b0;
          sr_r      <= '0;
          si_r      <= '0;
          qr_r      <= '0;
          qi_r      <= '0;
          if (in_acc) begin
            if (finger) begin
              sm_r   <= '0;
              fill_r <= '0;
              hop_r  <= '0;
              wp_r   <= '0;
              res_r  <= '{status: 1'b1, spo2_smoothed: '0, spo2_instant: '0,
                          ratio_r: '0};
            end else begin
              wp_r <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
              if (!fill_full) begin
                fill_r <= fill_r + FCW'(1);
              end else if (hop_fire) begin
                hop_r <= '0;
              end else begin
                hop_r <= hop_r + HCW'(1);
              end
            end
          end
        end
        ST_WALK: rd_addr_r <= rd_addr_r + AW'(1);
        ST_MULQ: if (mul_done) t_r <= mul_prod;
        ST_MULS: if (mul_done) v_r <= t_r - mul_prod;
        ST_SQRT: if (sq_done) root_r <= sq_root;
        ST_DIVA: begin
          if (s_zero || div_done) begin
            if (col_r) begin
              ai_r <= s_zero ? '0 : div_q[32:0];
            end else begin
              ar_r <= s_zero ? '0 : div_q[32:0];
            end
            col_r <= 1'b1;
          end
        end
        ST_DIVR: begin
          if (r_zero) begin
            rr_r <= R_MAX;
          end else if (div_done) begin
            rr_r <= (div_q > 64'(R_MAX)) ? R_MAX : div_q[19:0];
          end
        end
        ST_NUM: num_r <= $signed(NUM_BASE) - $signed({2'b00, slope_r});
        ST_DIVS: begin
          if (num_low) begin
            inst_r <= SPO2_LO;
          end else if (div_done) begin
            inst_r <= (div_q > 64'(SPO2_HI)) ? SPO2_HI : div_q[14:0];
          end
        end
        ST_SMOOTH: begin
          sm_r  <= sm_new;
          res_r <= '{status: 1'b0, spo2_smoothed: sm_new, spo2_instant: inst_r,
                     ratio_r: rr_r};
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= res_r;
    end
  end

  pox_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  pox_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v     (v_r),
    .root  (sq_root),
    .done  (sq_done)
  );

  pox_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .quo   (div_q),
    .done  (div_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_THRESH) ? 32'(thr_r) : 32'(keep_r);

  a_finger_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && finger |=> state_r == ST_EMIT)
    else $error("finger removal did not lead to a result");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.ratio_r == 20'd0 && out_data.spo2_instant == 15'd0 &&
      out_data.spo2_smoothed == 15'd0)
    else $error("finger removal word carries nonzero fields");

  a_inst_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.status |->
      out_data.spo2_instant >= SPO2_LO && out_data.spo2_instant <= SPO2_HI)
    else $error("instant estimate out of clamp range");

  a_unit_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start || sq_start || div_start) |=> launch_r)
    else $error("unit start not recorded");

endmodule
`default_nettype wire

>>> sim/pox_ratio_checker.sv
// ----------------------------------------------------------------------------
// pox_ratio_checker
// Watches the sample, result and register ports of the ratio block, keeps
// its own window, smoother and register copies, predicts every result word
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module pox_ratio_checker
  import pox_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam int WIN = WINDOW_DEF;
  localparam int HOPS = HOP_DEF;

  logic [17:0] red_win [WIN];
  logic [17:0] ir_win [WIN];
  int          wr_pos;
  int          filled;
  int          hop_cnt;
  logic [14:0] smooth_val;
  logic [17:0] thresh;
  logic [8:0]  keep_w;
  out_word_t   spo2_q[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // sqrt(V)/S in Q4.28, zero when the window sum is zero
  function automatic logic [63:0] color_ratio(input bit use_ir, output logic [63:0] sum);
    logic [63:0] q;
    logic [63:0] x;
    sum = 0;
    q = 0;
    for (int i = 0; i < WIN; i++) begin
      x = use_ir ? 64'(ir_win[i]) : 64'(red_win[i]);
      sum = sum + x;
      q = q + x * x;
    end
    if (sum == 0) return 0;
    return (int_sqrt(64'(WIN) * q - sum * sum) << 28) / sum;
  endfunction

  task automatic predict_word(input in_word_t w);
    out_word_t   o;
    logic [63:0] ar, ai, sr, si, r;
    longint      num;
    longint      inst;
    logic [63:0] k;
    if (filled >= WIN && w.ir_sample < thresh) begin
      smooth_val = 0;
      filled = 0;
      hop_cnt = 0;
      wr_pos = 0;
      o = '0;
      o.status = 1'b1;
      spo2_q.push_back(o);
      return;
    end
    red_win[wr_pos] = w.red_sample;
    ir_win[wr_pos] = w.ir_sample;
    wr_pos = (wr_pos + 1 >= WIN) ? 0 : wr_pos + 1;
    if (filled < WIN) begin
      filled++;
      return;
    end
    hop_cnt++;
    if (hop_cnt < HOPS) return;
    hop_cnt = 0;
    ar = color_ratio(1'b0, sr);
    ai = color_ratio(1'b1, si);
    if (sr == 0 || ai == 0) begin
      r = 64'(R_MAX);
    end else begin
      r = (ar << 16) / ai;
      if (r > 64'(R_MAX)) r = 64'(R_MAX);
    end
    num = longint'(NUM_BASE) - longint'(SLOPE) * longint'(r);
    if (num < longint'(NUM_LO)) inst = longint'(SPO2_LO);
    else begin
      inst = num / 25600;
      if (inst > longint'(SPO2_HI)) inst = longint'(SPO2_HI);
    end
    k = (keep_w > KEEP_MAX) ? 64'(KEEP_MAX) : 64'(keep_w);
    if (smooth_val == 0) smooth_val = 15'(inst);
    else smooth_val = 15'((k * 64'(smooth_val) + (64'd256 - k) * 64'(inst) + 64'd128) >> 8);
    o.status = 1'b0;
    o.spo2_smoothed = smooth_val;
    o.spo2_instant = 15'(inst);
    o.ratio_r = r[19:0];
    spo2_q.push_back(o);
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      wr_pos = 0;
      filled = 0;
      hop_cnt = 0;
      smooth_val = 0;
      thresh = THRESH_RST;
      keep_w = KEEP_RST;
      spo2_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (cfg_reg_t'(paddr[2]) == REG_THRESH) thresh = pwdata[17:0];
        else keep_w = pwdata[8:0];
      end
      if (out_valid && !out_stall) begin
        if (spo2_q.size() == 0) begin
          $error("result word with no prediction waiting");
          errors++;
        end else begin
          e = spo2_q.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_data.status);
            errors++;
          end
          if (out_data.spo2_smoothed !== e.spo2_smoothed) begin
            $error("spo2_smoothed: expected %0d actual %0d", e.spo2_smoothed,
                   out_data.spo2_smoothed);
            errors++;
          end
          if (out_data.spo2_instant !== e.spo2_instant) begin
            $error("spo2_instant: expected %0d actual %0d", e.spo2_instant,
                   out_data.spo2_instant);
            errors++;
          end
          if (out_data.ratio_r !== e.ratio_r) begin
            $error("ratio_r: expected %0d actual %0d", e.ratio_r, out_data.ratio_r);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_data);
    end
    pending = spo2_q.size();
  end

endmodule

>>> sim/pulse_oximetry_rms_ratio_tb.sv
// ----------------------------------------------------------------------------
// pulse_oximetry_rms_ratio_tb
// Drives sample words and register writes into the ratio block under random
// gaps and result stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module pulse_oximetry_rms_ratio_tb;
  import pox_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycle = 0;
  logic [17:0] cur_thresh = THRESH_RST;

  always #1 clk = ~clk;

  pulse_oximetry_rms_ratio dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pox_ratio_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  function automatic bit quiet();
    return cycle >= 20000 && cycle < 60000;
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= !quiet() && $urandom_range(99) < 32;

  task automatic send_word(input logic [17:0] red, input logic [17:0] ir);
    while (!quiet() && $urandom_range(99) < 32) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.red_sample <= red;
    in_data.ir_sample <= ir;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reg_write(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_THRESH) cur_thresh = val[17:0];
  endtask

  // Mostly finger-present pulse-like windows, with full-range noise and
  // the occasional removal.
  task automatic run_items(input int n);
    logic [17:0] br, bi, ar, ai, red, ir;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        br = 18'($urandom_range(262143));
        bi = 18'($urandom_range(262143, cur_thresh));
        ar = 18'($urandom_range(4000));
        ai = 18'($urandom_range(4000));
      end
      if ($urandom_range(99) < 15) begin
        red = 18'($urandom);
        ir = 18'($urandom);
      end else begin
        red = br + 18'($urandom_range(ar));
        ir = bi + 18'($urandom_range(ai));
        if (ir < bi) ir = 18'h3FFFF;
      end
      if (cur_thresh > 0 && $urandom_range(999) < 4)
        ir = 18'($urandom_range(cur_thresh - 1));
      send_word(red, ir);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Zero red sum: ratio saturates.
    for (int i = 0; i < 125; i++) send_word(18'd0, 18'd100000);
    send_word(18'h3FFFF, 18'd50000);
    send_word(18'd7, 18'd49999);
    // Flat infrared: zero deviation, ratio saturates.
    for (int i = 0; i < 125; i++) send_word(18'(i * 1000), 18'h3FFFF);
    send_word(18'd0, 18'd0);
    reg_write(REG_KEEP, 32'd0);
    reg_write(REG_THRESH, 32'd0);
    run_items(400);
    reg_write(REG_KEEP, 32'd256);
    run_items(300);
    reg_write(REG_THRESH, 32'd262143);
    reg_write(REG_KEEP, 32'd511);
    for (int i = 0; i < 110; i++) send_word(18'($urandom), 18'h3FFFF);
    for (int i = 0; i < 30; i++) send_word(18'($urandom), 18'($urandom));
    reg_write(REG_THRESH, 32'($urandom_range(90000)));
    reg_write(REG_KEEP, 32'($urandom_range(511)));
    run_items(400);
    reg_write(REG_THRESH, 32'd50000);
    reg_write(REG_KEEP, 32'd179);
    run_items(250);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
